// ===== hw/rtl/spq_pkg.sv =====
// package for the sorted priority queue: sizes, operation and status codes,
// and the structs passed between the queue cells
// no dependencies

package spq_pkg;

    // number of cells in the row
    localparam int CAPACITY = 16;
    // width of the entry counter, able to hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DATA_W = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int KIND_W = 2;
    localparam int STATUS_W = 2;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic                     clear;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // what one cell shows its right-hand neighbor
    typedef struct packed {
        logic                     valid;
        logic                     keep;   // valid and not larger than the new value
        logic signed [DATA_W-1:0] value;
    } t_link;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// sorted priority queue: a row of CAPACITY cells kept in ascending order
// result beat is registered and appears in the cycle after the input beat is accepted
// throughput: one operation per cycle unless a result beat is held by a stalled output
// all cells compare against the inserted value in parallel and shift in one step
// reset (synchronous, active low) empties the queue and drops any pending result
// depends on spq_pkg and spq_cell

module sorted_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // value [31:0]
    input  logic [spq_pkg::DATA_W-1:0]   i_s_tdata,
    // kind [1:0]
    input  logic [spq_pkg::KIND_W-1:0]   i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // status [1:0], head_value [33:2], entry_count [38:34], is_empty [39]
    output logic [39:0]                  o_m_tdata
);
    import spq_pkg::*;

    logic                      s_fire;
    logic [KIND_W-1:0]         kind;
    logic signed [DATA_W-1:0]  in_value;
    logic                      full;
    t_cmd                      cmd;
    t_link                     links [CAPACITY];
    t_link                     left_links [CAPACITY];
    logic [CAPACITY-1:0]       valid_vec;
    logic [CAPACITY-1:0]       right_valid;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  cur_head;
    logic signed [DATA_W-1:0]  head_raw;
    logic signed [DATA_W-1:0]  head;

    logic                      r_m_valid;
    logic [STATUS_W-1:0]       r_status;
    logic signed [DATA_W-1:0]  r_head;
    logic [ENTRY_COUNT_W-1:0]  r_entry_count;
    logic                      r_is_empty;

    // input handshake: a new beat goes in whenever the result slot frees up
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign kind       = i_s_tuser;
    assign in_value   = $signed(i_s_tdata);
    assign full       = (r_count >= CNT_W'(CAPACITY));

    // command to the cells
    always_comb begin
        cmd.insert = s_fire && (kind == KIND_INSERT) && !full;
        cmd.remove = s_fire && (kind == KIND_REMOVE) && (r_count != '0);
        cmd.clear  = s_fire && (kind == KIND_CLEAR);
        cmd.value  = in_value;
    end

    // row of cells; cell 0 sees a left neighbor that is valid and always kept
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left_links[g].valid = 1'b1;
                assign left_links[g].keep  = 1'b1;
                assign left_links[g].value = '0;
            end else begin : g_rest
                assign left_links[g] = links[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_valid[g] = 1'b0;
            end else begin : g_mid
                assign right_valid[g] = links[g+1].valid;
            end
            assign valid_vec[g] = links[g].valid;

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_left       (left_links[g]),
                .i_right_valid(right_valid[g]),
                .o_link       (links[g])
            );
        end
    endgenerate

    assign cur_head = links[0].valid ? links[0].value : '0;

    // status, count and head after the operation
    always_comb begin
        status   = ST_OK;
        n_count  = r_count;
        head_raw = cur_head;
        unique case (kind)
            KIND_PEEK: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end
            end
            KIND_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (!links[0].valid || (in_value < links[0].value)) begin
                        head_raw = in_value;
                    end
                end
            end
            KIND_REMOVE: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
        head = (n_count == '0) ? '0 : head_raw;
    end

    // entry counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (s_fire) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_fire) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_status      <= status;
            r_head        <= head;
            r_entry_count <= ENTRY_COUNT_W'(n_count);
            r_is_empty    <= (n_count == '0);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_is_empty, r_entry_count, r_head, r_status};

    // counter agrees with the number of valid cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("entry counter disagrees with valid cells");

    // valid cells form a prefix of the row
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid_vec & (valid_vec + CAPACITY'(1))) == '0))
        else $error("valid cells are not contiguous from the head");

    // head and second entry stay in order
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        links[1].valid |-> (links[0].value <= links[1].value))
        else $error("head entry larger than its neighbor");

    // an insert into a full queue leaves the count unchanged
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && (kind == KIND_INSERT) && full) |=> (r_count == CNT_W'(CAPACITY)))
        else $error("insert into full queue changed the count");

endmodule

// ===== hw/rtl/spq_cell.sv =====
// one cell of the sorted queue row: holds one entry and its valid bit
// depends on spq_pkg

module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cmd  i_cmd,
    input  spq_pkg::t_link i_left,
    input  logic           i_right_valid,
    output spq_pkg::t_link o_link
);
    import spq_pkg::*;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     keep;

    // entry stays in place on insert when it is not larger than the new value
    assign keep = r_valid && (r_value <= i_cmd.value);

    // next entry: keep, take the new value, or take the left neighbor's
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.insert) begin
            n_valid = r_valid | i_left.valid;
            if (!keep) begin
                n_value = i_left.keep ? i_cmd.value : i_left.value;
            end
        end else if (i_cmd.remove) begin
            // the tail cell is the last valid one: it drops out
            n_valid = r_valid & i_right_valid;
        end
    end

    // valid bit is control, entry value is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.keep  = keep;
    assign o_link.value = r_value;

endmodule

// ===== tb/sorted_priority_queue_checker.sv =====
// checker for sorted_priority_queue: mirrors the sorted row of entries, predicts one
// report per accepted operation beat and compares each result beat field by field
// depends on spq_pkg

module sorted_priority_queue_checker
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // value [31:0]
    input  logic [DATA_W-1:0]         i_s_tdata,
    // kind [1:0]
    input  logic [KIND_W-1:0]         i_s_tuser,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // status [1:0], head_value [33:2], entry_count [38:34], is_empty [39]
    input  logic [39:0]               i_m_tdata,
    output int                        o_fail_count,
    output int                        o_pending_count
);

    // one result beat, laid out as on the master data bus
    typedef struct packed {
        logic                      is_empty;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
        logic signed [DATA_W-1:0]  head_value;
        logic [STATUS_W-1:0]       status;
    } t_queue_report;

    // mirrored queue contents, ascending from index 0
    logic signed [DATA_W-1:0] mirror_entries[$];
    // reports still owed by the block, oldest first
    t_queue_report            owed_reports[$];
    t_queue_report            seen_report;
    t_queue_report            owed_report;
    int                       fail_count = 0;

    assign o_fail_count = fail_count;

    // apply one operation to the mirror and return the report it should produce
    function automatic t_queue_report apply_queue_op(
        input logic [KIND_W-1:0]        kind,
        input logic signed [DATA_W-1:0] value
    );
        t_queue_report rep;
        int            pos;
        rep.status = ST_OK;
        pos = 0;
        case (kind)
            KIND_PEEK: begin
                if (mirror_entries.size() == 0) rep.status = ST_EMPTY;
            end
            KIND_INSERT: begin
                if (mirror_entries.size() >= CAPACITY) begin
                    rep.status = ST_FULL;
                end else begin
                    // equal values go behind the ones already stored
                    while (pos < mirror_entries.size() && mirror_entries[pos] <= value)
                        pos++;
                    mirror_entries.insert(pos, value);
                end
            end
            KIND_REMOVE: begin
                if (mirror_entries.size() == 0) rep.status = ST_EMPTY;
                else void'(mirror_entries.pop_back());
            end
            default: begin
                mirror_entries.delete();
            end
        endcase
        rep.head_value  = (mirror_entries.size() > 0) ? mirror_entries[0] : '0;
        rep.entry_count = ENTRY_COUNT_W'(mirror_entries.size());
        rep.is_empty    = (mirror_entries.size() == 0);
        return rep;
    endfunction

    task automatic check_field(
        input string             field,
        input logic [DATA_W-1:0] want,
        input logic [DATA_W-1:0] seen
    );
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, seen);
            fail_count++;
        end
    endtask

    // retire result beats first, then queue the report for a new operation beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mirror_entries.delete();
            owed_reports.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen_report = t_queue_report'(i_m_tdata);
                if (owed_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, i_m_tdata);
                    fail_count++;
                end else begin
                    owed_report = owed_reports.pop_front();
                    check_field("status", DATA_W'(owed_report.status),
                                DATA_W'(seen_report.status));
                    check_field("head_value", owed_report.head_value,
                                seen_report.head_value);
                    check_field("entry_count", DATA_W'(owed_report.entry_count),
                                DATA_W'(seen_report.entry_count));
                    check_field("is_empty", DATA_W'(owed_report.is_empty),
                                DATA_W'(seen_report.is_empty));
                end
            end
            if (i_s_tvalid && i_s_tready)
                owed_reports.push_back(apply_queue_op(i_s_tuser, i_s_tdata));
        end
        o_pending_count <= owed_reports.size();
    end

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
// testbench top for sorted_priority_queue: drives operation beats with random gaps
// and output stalls, and gives the verdict from the checker's failure count
// depends on spq_pkg, sorted_priority_queue and sorted_priority_queue_checker

module sorted_priority_queue_tb;

    import spq_pkg::*;

    localparam int RANDOM_OPS   = 1350;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_NEG_ONE = {DATA_W{1'b1}};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata;
    logic [KIND_W-1:0] i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [39:0]       o_m_tdata;

    int                fail_count;
    int                pending_count;
    int unsigned       cycle_count = 0;
    int                stall_left = 0;
    int                quiet_left = 0;
    int                rx_roll;

    sorted_priority_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    sorted_priority_queue_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // 4 unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side backpressure: short random stalls, rare long ones, calm stretches
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (quiet_left > 0) begin
            i_m_tready <= 1'b1;
            quiet_left <= quiet_left - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            i_m_tready <= (rx_roll >= 25);
            if (rx_roll < 3) stall_left <= $urandom_range(8, 40);
            else if (rx_roll >= 95) quiet_left <= $urandom_range(20, 80);
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return VAL_NEG_ONE;
            4, 5:    return DATA_W'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // hold one operation beat until accepted, then drop valid for the given gap
    task automatic issue_op(
        input logic [KIND_W-1:0] kind,
        input logic [DATA_W-1:0] value,
        input int                gap
    );
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int                mode;
        int                phase_left;
        int                roll;
        int                sent;
        bit                calm;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_PEEK;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: peek, remove and clear
        issue_op(KIND_PEEK, VAL_NEG_ONE, $urandom_range(0, 1));
        issue_op(KIND_REMOVE, VAL_MAX, $urandom_range(0, 1));
        issue_op(KIND_CLEAR, VAL_MIN, $urandom_range(0, 1));
        // extremes and a repeated minimum
        issue_op(KIND_INSERT, VAL_MAX, $urandom_range(0, 1));
        issue_op(KIND_INSERT, VAL_MIN, $urandom_range(0, 1));
        issue_op(KIND_INSERT, '0, $urandom_range(0, 1));
        issue_op(KIND_INSERT, VAL_NEG_ONE, $urandom_range(0, 1));
        issue_op(KIND_INSERT, VAL_MIN, $urandom_range(0, 1));
        issue_op(KIND_PEEK, '0, $urandom_range(0, 1));
        issue_op(KIND_REMOVE, '0, $urandom_range(0, 1));
        // fill up, then overflow
        for (int i = 0; i < 12; i++)
            issue_op(KIND_INSERT, DATA_W'(6 - i), $urandom_range(0, 1));
        issue_op(KIND_INSERT, VAL_MIN, $urandom_range(0, 1));
        issue_op(KIND_PEEK, '0, $urandom_range(0, 1));
        issue_op(KIND_REMOVE, '0, $urandom_range(0, 1));
        issue_op(KIND_CLEAR, '0, $urandom_range(0, 1));

        // random phases: filling, draining, mixed, and crowded with equal values
        sent = 0;
        phase_left = 0;
        while (sent < RANDOM_OPS) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 60);
                mode       = $urandom_range(0, 3);
                calm       = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                kind = KIND_CLEAR;
            end else if (roll < 14) begin
                kind = KIND_PEEK;
            end else begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       kind = (roll < 75) ? KIND_INSERT : KIND_REMOVE;
                    1:       kind = (roll < 30) ? KIND_INSERT : KIND_REMOVE;
                    default: kind = (roll < 55) ? KIND_INSERT : KIND_REMOVE;
                endcase
            end
            value = (mode == 3) ? DATA_W'($signed($urandom_range(0, 4)) - 2) : pick_value();
            issue_op(kind, value, pick_gap(calm));
            sent++;
            phase_left--;
        end
        i_s_tvalid <= 1'b0;

        // wait for every owed report, then drain for strays
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
